// ----- rtl/mf3x3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the 3x3 median filter.
package mf3x3_pkg;

	// Configuration register file
	localparam int PADDR_BITS      = 3;
	localparam int REG_INDEX_LSB   = 2;
	localparam int WIDTH_REG_BITS  = 11;
	localparam int HEIGHT_REG_BITS = 13;

	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 13'd480;

	// Frame size limits
	localparam int MIN_SIZE     = 3;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int ROW_BITS     = 13;

	// Control bits that travel with a window through the median stages
	typedef struct packed {
		logic valid;
		logic zero;
		logic last;
	} ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/mf3x3_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Stream interfaces for source pixels and filtered results.
interface mf3x3_pixel_if #(
	parameter int PIXEL_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic                  action;
	logic [PIXEL_BITS-1:0] pixel_in;

	modport source (output valid, output action, output pixel_in, input ready);
	modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface mf3x3_result_if #(
	parameter int PIXEL_BITS = 8
) ();
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_out;
	logic                  frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/median_filter_3x3.sv -----
`timescale 1ns / 1ps
`default_nettype none
// 3x3 median filter over a raster stream of grayscale pixels.
// pixel_stream carries one item per transfer: action 0 is a frame pixel,
// action 1 a flush tick. A flush tick inside the frame is dropped; once all
// width*height pixels are in, every item (pixel or flush) drains one more
// position. The result for pixel (r,c) is caused by the item at raster
// position r*W+c+W+1, so a frame needs W+1 drain items after its last pixel.
// median_stream carries pixel_out (median of the window, zero on the frame
// border) and frame_last, set on the final result of the frame.
// A result leaves on median_stream after the item that causes it passes the
// line buffer read, window shift, three median stages and output queue.
// Throughput: one item per cycle while the stages do not hold, set by the single
// line buffer read and write port per cycle.
// A two-entry output queue lets the input keep taking items while a result
// waits; when the queue is full and a result is ready, all stages hold and
// pixel_stream.ready drops until median_stream takes a result.
// Reset sets the size registers to 640x480 and the raster position to the
// frame start. A register write over the APB port also restarts the frame.
module median_filter_3x3 #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mf3x3_pixel_if.sink                      pixel_stream,
	mf3x3_result_if.source                   median_stream,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mf3x3_pkg::PADDR_BITS-1:0] paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PB = PIXEL_BITS;
	localparam int RB = mf3x3_pkg::ROW_BITS;
	localparam logic [1:0] QUEUE_FULL = 2'd2;

	// Configuration registers and raster position
	logic [mf3x3_pkg::WIDTH_REG_BITS-1:0]  width_q;
	logic [mf3x3_pkg::HEIGHT_REG_BITS-1:0] height_q;
	logic [CW-1:0]                         col_q;
	logic [RB-1:0]                         row_q;

	logic          cfg_wr;
	logic          reg_idx;
	logic [WW-1:0] eff_w;
	logic [RB-1:0] eff_h;

	// Position decode
	logic          en;
	logic          in_xfer;
	logic          pixel_phase;
	logic          step;
	logic          emit;
	logic          zero;
	logic          last;
	logic [CW:0]   col_inc;
	logic          col_wrap;

	// Stage 1
	logic          v_s1, drain_s1, emit_s1, zero_s1, last_s1;
	logic [PB-1:0] px_s1;
	logic [CW-1:0] col_s1;

	// Line buffer
	logic            lb_rd_en, lb_wr_en;
	logic [CW-1:0]   lb_rd_addr, lb_wr_addr;
	logic [2*PB-1:0] lb_rd_data, lb_wr_data;

	// Window chain
	logic                  shift;
	logic [PB-1:0]         col_new [3];
	logic [PB-1:0]         col_c2 [3];
	logic [PB-1:0]         col_c1 [3];
	logic [PB-1:0]         lo_col [3];
	logic [PB-1:0]         md_col [3];
	logic [PB-1:0]         hi_col [3];
	mf3x3_pkg::ctrl_t      ctrl_s2;
	mf3x3_pkg::ctrl_t      ctrl_s5;
	logic [PB-1:0]         med_s5;

	// Output queue
	logic [PB-1:0] queue_pix_q [2];
	logic          queue_last_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic          push, pop;

	// APB register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[mf3x3_pkg::REG_INDEX_LSB];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			mf3x3_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
			mf3x3_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3x3_pkg::WIDTH_RESET;
			height_q <= mf3x3_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				mf3x3_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[mf3x3_pkg::WIDTH_REG_BITS-1:0];
				mf3x3_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[mf3x3_pkg::HEIGHT_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the frame size into its legal range
	always_comb begin
		if (32'(width_q) < 32'(mf3x3_pkg::MIN_SIZE)) begin
			eff_w = WW'(mf3x3_pkg::MIN_SIZE);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
		if (32'(height_q) < 32'(mf3x3_pkg::MIN_SIZE)) begin
			eff_h = RB'(mf3x3_pkg::MIN_SIZE);
		end else if (32'(height_q) > 32'(mf3x3_pkg::HEIGHT_LIMIT)) begin
			eff_h = RB'(mf3x3_pkg::HEIGHT_LIMIT);
		end else begin
			eff_h = RB'(height_q);
		end
	end

	// Global advance: hold every stage while a result waits on a full queue
	assign en                 = !(ctrl_s5.valid && count_q == QUEUE_FULL);
	assign pixel_stream.ready = en;
	assign in_xfer            = pixel_stream.valid && pixel_stream.ready;

	// Decode the raster position of the incoming item
	always_comb begin
		pixel_phase = row_q < eff_h;
		step        = in_xfer && !(pixel_phase && pixel_stream.action);
		emit        = (row_q >= RB'(2)) || (row_q == RB'(1) && col_q != '0);
		zero        = (col_q == CW'(0)) || (col_q == CW'(1)) || (row_q == RB'(1))
			|| (row_q >= eff_h);
		last        = (row_q == eff_h + RB'(1)) && (col_q == '0);
		col_inc     = {1'b0, col_q} + (CW + 1)'(1);
		col_wrap    = 32'(col_inc) >= 32'(eff_w);
	end

	// Advance the raster position; restart on frame end or register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + RB'(1);
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			drain_s1 <= !pixel_phase;
			emit_s1  <= emit;
			zero_s1  <= zero;
			last_s1  <= last;
			px_s1    <= pixel_stream.pixel_in;
			col_s1   <= col_q;
		end
	end

	// Read both rows at transfer; write back the rotated column from the stage 1 registers
	assign lb_rd_en   = step && pixel_phase;
	assign lb_rd_addr = col_q;
	assign lb_wr_en   = en && v_s1 && !drain_s1;
	assign lb_wr_addr = col_s1;
	assign lb_wr_data = {lb_rd_data[PB-1:0], px_s1};

	mf3x3_line_buffer #(
		.DEPTH     (MAX_WIDTH),
		.DATA_BITS (2 * PB)
	) u_line_buffer (
		.clk     (clk),
		.rd_en   (lb_rd_en),
		.rd_addr (lb_rd_addr),
		.rd_data (lb_rd_data),
		.wr_en   (lb_wr_en),
		.wr_addr (lb_wr_addr),
		.wr_data (lb_wr_data)
	);

	// New window column: top, middle, bottom, or zeros while draining
	assign shift      = en && v_s1;
	assign col_new[0] = drain_s1 ? '0 : lb_rd_data[2*PB-1:PB];
	assign col_new[1] = drain_s1 ? '0 : lb_rd_data[PB-1:0];
	assign col_new[2] = drain_s1 ? '0 : px_s1;

	mf3x3_wcell #(.PIXEL_BITS(PB)) u_wcell_new (
		.clk     (clk),
		.shift   (shift),
		.col_in  (col_new),
		.col_out (col_c2),
		.lo      (lo_col[2]),
		.md      (md_col[2]),
		.hi      (hi_col[2])
	);

	mf3x3_wcell #(.PIXEL_BITS(PB)) u_wcell_mid (
		.clk     (clk),
		.shift   (shift),
		.col_in  (col_c2),
		.col_out (col_c1),
		.lo      (lo_col[1]),
		.md      (md_col[1]),
		.hi      (hi_col[1])
	);

	mf3x3_wcell #(.PIXEL_BITS(PB)) u_wcell_old (
		.clk     (clk),
		.shift   (shift),
		.col_in  (col_c1),
		.col_out (),
		.lo      (lo_col[0]),
		.md      (md_col[0]),
		.hi      (hi_col[0])
	);

	// Stage 2 control: only items that produce a result go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2.valid <= v_s1 && emit_s1;
			ctrl_s2.zero  <= zero_s1;
			ctrl_s2.last  <= last_s1;
		end
	end

	mf3x3_median #(.PIXEL_BITS(PB)) u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctrl_in  (ctrl_s2),
		.lo_col   (lo_col),
		.md_col   (md_col),
		.hi_col   (hi_col),
		.ctrl_out (ctrl_s5),
		.median   (med_s5)
	);

	// Output queue
	assign push = en && ctrl_s5.valid;
	assign pop  = median_stream.valid && median_stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_pix_q[wr_ptr_q]  <= ctrl_s5.zero ? '0 : med_s5;
			queue_last_q[wr_ptr_q] <= ctrl_s5.last;
		end
	end

	assign median_stream.valid      = count_q != '0;
	assign median_stream.pixel_out  = queue_pix_q[rd_ptr_q];
	assign median_stream.frame_last = queue_last_q[rd_ptr_q];

`ifndef NO_ASSERTIONS
	a_last_on_border: assert property (@(posedge clk) disable iff (!arst_n)
		median_stream.valid && median_stream.frame_last |-> median_stream.pixel_out == '0)
		else $error("frame_last result is not a border zero");

	a_lb_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		lb_rd_en && lb_wr_en |-> lb_rd_addr != lb_wr_addr)
		else $error("line buffer read and write hit the same column");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr && $past(!cfg_wr) |-> 32'(col_q) < 32'(eff_w))
		else $error("column position beyond the image width");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != QUEUE_FULL)
		else $error("result pushed into a full output queue");
`endif
endmodule
`default_nettype wire

// ----- rtl/mf3x3_line_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Line buffer memory holding the two previous rows, one word per column.
module mf3x3_line_buffer #(
	parameter int DEPTH     = 1024,
	parameter int DATA_BITS = 16
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_BITS-1:0]     rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_BITS-1:0]     wr_data
);
	logic [DATA_BITS-1:0] mem [DEPTH];

	// Write one column word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/mf3x3_wcell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Window cell: holds one three-pixel column, passes it on, and sorts it.
module mf3x3_wcell #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  shift,
	input  logic [PIXEL_BITS-1:0] col_in [3],
	output logic [PIXEL_BITS-1:0] col_out [3],
	output logic [PIXEL_BITS-1:0] lo,
	output logic [PIXEL_BITS-1:0] md,
	output logic [PIXEL_BITS-1:0] hi
);
	logic [PIXEL_BITS-1:0] col_q [3];
	logic [PIXEL_BITS-1:0] l1, h1, l2;

	// Take the neighbor's column on a shift
	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Sort the column with three compare-exchange steps
	always_comb begin
		l1 = (col_q[0] < col_q[1]) ? col_q[0] : col_q[1];
		h1 = (col_q[0] < col_q[1]) ? col_q[1] : col_q[0];
		l2 = (h1 < col_q[2]) ? h1 : col_q[2];
		hi = (h1 < col_q[2]) ? col_q[2] : h1;
		lo = (l1 < l2) ? l1 : l2;
		md = (l1 < l2) ? l2 : l1;
	end
endmodule
`default_nettype wire

// ----- rtl/mf3x3_median.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Median stages: reduce three sorted columns to the median of nine.
module mf3x3_median #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  mf3x3_pkg::ctrl_t      ctrl_in,
	input  logic [PIXEL_BITS-1:0] lo_col [3],
	input  logic [PIXEL_BITS-1:0] md_col [3],
	input  logic [PIXEL_BITS-1:0] hi_col [3],
	output mf3x3_pkg::ctrl_t      ctrl_out,
	output logic [PIXEL_BITS-1:0] median
);
	mf3x3_pkg::ctrl_t      ctrl_s3, ctrl_s4, ctrl_s5;
	logic [PIXEL_BITS-1:0] lo_s3 [3];
	logic [PIXEL_BITS-1:0] md_s3 [3];
	logic [PIXEL_BITS-1:0] hi_s3 [3];
	logic [PIXEL_BITS-1:0] max_lo_s4, med_md_s4, min_hi_s4;
	logic [PIXEL_BITS-1:0] med_s5;

	function automatic logic [PIXEL_BITS-1:0] f_min(
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b
	);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] f_max(
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b
	);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] f_med3(
		input logic [PIXEL_BITS-1:0] a,
		input logic [PIXEL_BITS-1:0] b,
		input logic [PIXEL_BITS-1:0] c
	);
		return f_max(f_min(a, b), f_min(f_max(a, b), c));
	endfunction

	// Advance the control bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_in;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	// Capture sorted columns, then max of lows, median of mids, min of highs, then median
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3     <= lo_col;
			md_s3     <= md_col;
			hi_s3     <= hi_col;
			max_lo_s4 <= f_max(f_max(lo_s3[0], lo_s3[1]), lo_s3[2]);
			med_md_s4 <= f_med3(md_s3[0], md_s3[1], md_s3[2]);
			min_hi_s4 <= f_min(f_min(hi_s3[0], hi_s3[1]), hi_s3[2]);
			med_s5    <= f_med3(max_lo_s4, med_md_s4, min_hi_s4);
		end
	end

	assign ctrl_out = ctrl_s5;
	assign median   = med_s5;
endmodule
`default_nettype wire
